[sv/cosine_similarity_unit_assert.svh]
// Assertion macros for the cosine similarity unit.
`ifndef COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CSU_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CSU_ASSERT(label, clk, rst_n, prop)
`define CSU_ASSERT_RST(label, clk, prop)
`endif
`endif

[sv/csu_pkg.sv]
// Package with shared types and constants of the cosine similarity unit.
`default_nettype none
package csu_pkg;
  localparam int MaxElementsDefault = 64;
  localparam int DotW  = 37;
  localparam int NormW = 36;
  localparam int ProdW = 72;
  localparam int RootW = 37;
  localparam int QuotW = 52;

  typedef enum logic [2:0] {
    ST_ACC, ST_MUL, ST_SQRT, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic acc_en;
    logic clear;
    logic start_mul;
    logic sqrt_step;
    logic start_div;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic zero_norm;
    logic last_step;
  } sts_t;
endpackage
`default_nettype wire

[sv/csu_ctrl.sv]
// Controller state machine of the cosine similarity unit.
`default_nettype none
`include "cosine_similarity_unit_assert.svh"
module csu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_last_pair,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire csu_pkg::sts_t  sts,
  output csu_pkg::cmd_t       cmd
);
  csu_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csu_pkg::ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      csu_pkg::ST_ACC: begin
        in_ready   = 1'b1;
        cmd.acc_en = in_valid;
        if (in_valid && in_last_pair) begin
          state_nxt = csu_pkg::ST_MUL;
        end
      end
      csu_pkg::ST_MUL: begin
        cmd.start_mul = 1'b1;
        state_nxt     = csu_pkg::ST_SQRT;
      end
      csu_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.last_step) begin
          state_nxt = csu_pkg::ST_DIV;
        end
      end
      csu_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.last_step) begin
          state_nxt = csu_pkg::ST_OUT;
        end
      end
      csu_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          cmd.clear     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = csu_pkg::ST_ACC;
        end
      end
      default: state_nxt = csu_pkg::ST_ACC;
    endcase
    cmd.start_div = (state_r == csu_pkg::ST_SQRT) && sts.last_step;
  end

  `CSU_ASSERT(a_no_in_busy, clk, rst_n, (state_r != csu_pkg::ST_ACC) |-> !in_ready)
  `CSU_ASSERT(a_last_goes_mul, clk, rst_n,
    (in_valid && in_ready && in_last_pair) |=> (state_r == csu_pkg::ST_MUL))
  `CSU_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
endmodule
`default_nettype wire

[sv/csu_datapath.sv]
// Datapath: accumulators, product multiplier, square root and divider.
`default_nettype none
module csu_datapath #(
  parameter int MAX_ELEMENTS = csu_pkg::MaxElementsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic signed [15:0] in_elem_a,
  input  wire logic signed [15:0] in_elem_b,
  input  wire csu_pkg::cmd_t      cmd,
  output csu_pkg::sts_t           sts,
  output logic signed [15:0]      out_similarity,
  output logic                    out_zero_norm
);
  localparam int CntW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ELEMENTS);
  localparam logic signed [csu_pkg::DotW-1:0] DotMax = {1'b0, {(csu_pkg::DotW-1){1'b1}}};
  localparam logic signed [csu_pkg::DotW-1:0] DotMin = {1'b1, {(csu_pkg::DotW-1){1'b0}}};

  logic signed [csu_pkg::DotW-1:0] dot_r;
  logic [csu_pkg::NormW-1:0] na_r, nb_r;
  logic [CntW-1:0] cnt_r;
  logic signed [31:0] pab, paa, pbb;
  logic signed [csu_pkg::DotW:0] dsum;
  logic [csu_pkg::NormW:0] asum, bsum;

  assign pab  = in_elem_a * in_elem_b;
  assign paa  = in_elem_a * in_elem_a;
  assign pbb  = in_elem_b * in_elem_b;
  assign dsum = {dot_r[csu_pkg::DotW-1], dot_r} + (csu_pkg::DotW+1)'(pab);
  assign asum = {1'b0, na_r} + (csu_pkg::NormW+1)'($unsigned(paa));
  assign bsum = {1'b0, nb_r} + (csu_pkg::NormW+1)'($unsigned(pbb));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.acc_en && cnt_r < CntMax) begin
      cnt_r <= cnt_r + 1'b1;
      if (dsum[csu_pkg::DotW] != dsum[csu_pkg::DotW-1]) begin
        dot_r <= dsum[csu_pkg::DotW] ? DotMin : DotMax;
      end else begin
        dot_r <= dsum[csu_pkg::DotW-1:0];
      end
      na_r <= asum[csu_pkg::NormW] ? '1 : asum[csu_pkg::NormW-1:0];
      nb_r <= bsum[csu_pkg::NormW] ? '1 : bsum[csu_pkg::NormW-1:0];
    end
  end

  // The 36x36 product is built from two 36x18 partial products, the low one first.
  logic [csu_pkg::ProdW-1:0] prod_r;
  logic [53:0] part_r;
  logic [53:0] part_hi;
  logic mul_phase_r;
  logic [5:0] step_r;
  logic [csu_pkg::RootW-1:0] root_r;
  logic [csu_pkg::ProdW+1:0] rem_r;
  logic [csu_pkg::ProdW+1:0] trial;
  logic [csu_pkg::ProdW+1:0] rem_sh;
  logic [csu_pkg::QuotW-1:0] num_r, quo_r;
  logic [csu_pkg::RootW:0] drem_r, dsh, dden;
  logic neg_r, zero_r;
  logic [csu_pkg::DotW-1:0] mag;

  assign mag = dot_r[csu_pkg::DotW-1] ? csu_pkg::DotW'(-dot_r) : csu_pkg::DotW'(dot_r);
  assign part_hi = na_r * nb_r[35:18];

  // Restoring square root, one result bit per step.
  assign rem_sh = {rem_r[csu_pkg::ProdW-1:0],
                   prod_r[csu_pkg::ProdW-1 -: 2]};
  assign trial  = {(csu_pkg::ProdW+2-csu_pkg::RootW-2)'(0), root_r, 2'b01};
  assign dden   = {1'b0, (root_r == '0) ? csu_pkg::RootW'(1) : root_r};
  assign dsh    = {drem_r[csu_pkg::RootW-1:0], num_r[csu_pkg::QuotW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      mul_phase_r <= 1'b0;
    end else if (cmd.start_mul) begin
      part_r      <= na_r * nb_r[17:0];
      mul_phase_r <= 1'b1;
      step_r      <= '0;
      rem_r       <= '0;
      root_r      <= '0;
      neg_r       <= dot_r[csu_pkg::DotW-1];
      zero_r      <= (na_r == '0) || (nb_r == '0);
      num_r       <= {mag, 15'd0};
    end else if (cmd.sqrt_step) begin
      if (mul_phase_r) begin
        prod_r      <= {part_hi, 18'd0} + csu_pkg::ProdW'(part_r);
        mul_phase_r <= 1'b0;
      end else begin
        prod_r <= {prod_r[csu_pkg::ProdW-3:0], 2'b00};
        step_r <= step_r + 1'b1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[csu_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[csu_pkg::RootW-2:0], 1'b0};
        end
      end
      if (cmd.start_div) begin
        step_r <= '0;
        drem_r <= '0;
      end
    end else if (cmd.div_step) begin
      step_r <= step_r + 1'b1;
      num_r  <= {num_r[csu_pkg::QuotW-2:0], 1'b0};
      if (dsh >= dden) begin
        drem_r <= dsh - dden;
        quo_r  <= {quo_r[csu_pkg::QuotW-2:0], 1'b1};
      end else begin
        drem_r <= dsh;
        quo_r  <= {quo_r[csu_pkg::QuotW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sts.zero_norm = zero_r;
    sts.last_step = 1'b0;
    if (cmd.sqrt_step) begin
      sts.last_step = !mul_phase_r && (step_r == 6'(csu_pkg::ProdW/2 - 1));
    end else if (cmd.div_step) begin
      sts.last_step = (step_r == 6'(csu_pkg::QuotW - 1));
    end
  end

  logic signed [15:0] sim_r;
  logic zn_r;
  logic signed [15:0] sat;
  always_comb begin
    if (zero_r) begin
      sat = '0;
    end else if (neg_r) begin
      sat = (quo_r > csu_pkg::QuotW'(32768)) ? 16'sh8000 : 16'(-quo_r[15:0]);
    end else begin
      sat = (quo_r > csu_pkg::QuotW'(32767)) ? 16'sh7fff : quo_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sim_r <= sat;
      zn_r  <= zero_r;
    end
  end
  assign out_similarity = sim_r;
  assign out_zero_norm  = zn_r;
endmodule
`default_nettype wire

[sv/cosine_similarity_unit.sv]
// Top level of the cosine similarity unit.
//
//   Channel | Ports                                  | Direction
//   input   | in_valid/in_ready, elem_a/b, last_pair | into the unit
//   result  | out_valid/out_ready, similarity, flag  | out of the unit
//
// A pair is taken each cycle while accumulating. After the last pair the
// unit runs the two-part multiply, 36 square-root steps and 52 divide steps,
// then loads the output register and takes pairs again.
// Reset is synchronous and clears the sums and the controller.
// A stalled result holds the next result in the final state until the transfer.
`default_nettype none
module cosine_similarity_unit #(
  parameter int MAX_ELEMENTS = csu_pkg::MaxElementsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_elem_a,
  input  wire logic signed [15:0] in_elem_b,
  input  wire logic               in_last_pair,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_similarity,
  output logic                    out_zero_norm
);
  csu_pkg::cmd_t cmd;
  csu_pkg::sts_t sts;

  // The controller sequences accumulation, the root and the division.
  csu_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_last_pair, .in_ready,
    .out_valid, .out_ready, .sts, .cmd
  );

  // The datapath holds the sums and the iterative arithmetic units.
  csu_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk, .rst_n, .in_elem_a, .in_elem_b, .cmd, .sts,
    .out_similarity, .out_zero_norm
  );
endmodule
`default_nettype wire

[dv/cosine_similarity_unit_tb.sv]
// Self-checking testbench for the cosine similarity unit.
`timescale 1ns / 100ps
`default_nettype none
module cosine_similarity_unit_tb;

  localparam int MaxElements = 64;
  localparam int DrainCycles = 200;
  localparam int IdleLimit   = 20000;
  localparam int RandomPairs = 360;

  typedef struct packed {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last_pair;
  } pair_t;

  typedef struct packed {
    logic signed [15:0] similarity;
    logic               zero_norm;
  } cosine_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_elem_a = '0;
  logic signed [15:0] in_elem_b = '0;
  logic in_last_pair = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_similarity;
  logic out_zero_norm;

  cosine_similarity_unit #(.MAX_ELEMENTS(MaxElements)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_elem_a     (in_elem_a),
    .in_elem_b     (in_elem_b),
    .in_last_pair  (in_last_pair),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_similarity(out_similarity),
    .out_zero_norm (out_zero_norm)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pairs waiting to be driven and similarities still owed by the unit.
  pair_t   pending_pairs[$];
  cosine_t owed_cosines[$];
  int      fail_count = 0;
  int      send_idle_pct = 37;
  int      recv_idle_pct = 50;
  int      hold_off_cycles = 0;
  bit      sending = 1'b0;
  // Set at each rising edge when the presented pair made its transfer.
  bit      in_fired = 1'b0;

  // Predictor state, cleared after every vector.
  logic signed [36:0] dot_acc = '0;
  logic [35:0]        norm_a_acc = '0;
  logic [35:0]        norm_b_acc = '0;
  int                 pairs_taken = 0;

  // floor(sqrt(p)) for a 72-bit product, bit by bit from the top.
  function automatic logic [36:0] root_of(input logic [71:0] p);
    logic [36:0] r;
    logic [36:0] c;
    r = '0;
    for (int i = 36; i >= 0; i--) begin
      c = r | (37'd1 << i);
      if ({39'd0, c} * {39'd0, c} <= {4'd0, p}) r = c;
    end
    return r;
  endfunction

  // Folds one accepted pair into the sums and, on the last pair, owes a result.
  task automatic absorb_pair(input pair_t p);
    logic signed [38:0] dot_next;
    logic [36:0]        na_next;
    logic [36:0]        nb_next;
    logic [36:0]        den;
    logic [36:0]        mag;
    logic [51:0]        quo;
    cosine_t            r;
    if (pairs_taken < MaxElements) begin
      dot_next = 39'(dot_acc) + 39'(p.elem_a * p.elem_b);
      na_next  = 37'(norm_a_acc) + 37'(32'(p.elem_a * p.elem_a));
      nb_next  = 37'(norm_b_acc) + 37'(32'(p.elem_b * p.elem_b));
      if (dot_next > 39'sd68719476735) dot_next = 39'sd68719476735;
      if (dot_next < -39'sd68719476736) dot_next = -39'sd68719476736;
      norm_a_acc = na_next[36] ? '1 : na_next[35:0];
      norm_b_acc = nb_next[36] ? '1 : nb_next[35:0];
      dot_acc = dot_next[36:0];
      pairs_taken++;
    end
    if (!p.last_pair) return;
    if (norm_a_acc == 0 || norm_b_acc == 0) begin
      r.similarity = '0;
      r.zero_norm = 1'b1;
    end else begin
      den = root_of({36'd0, norm_a_acc} * {36'd0, norm_b_acc});
      if (den == 0) den = 1;
      mag = dot_acc[36] ? 37'(-dot_acc) : 37'(dot_acc);
      quo = ({15'd0, mag} << 15) / {15'd0, den};
      if (dot_acc[36]) r.similarity = (quo > 32768) ? -16'sd32768 : 16'(-quo);
      else r.similarity = (quo > 32767) ? 16'sd32767 : 16'(quo);
      r.zero_norm = 1'b0;
    end
    owed_cosines.insert(owed_cosines.size(), r);
    dot_acc = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    pairs_taken = 0;
  endtask

  // Driver: presents queued pairs at the falling edge and holds each one until its transfer.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_fired) begin
        // Hold the current pair.
      end else if (sending && pending_pairs.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_valid     <= 1'b1;
        in_elem_a    <= pending_pairs[0].elem_a;
        in_elem_b    <= pending_pairs[0].elem_b;
        in_last_pair <= pending_pairs[0].last_pair;
        void'(pending_pairs.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: drives out_ready at the falling edge and counts down long hold-offs.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles <= hold_off_cycles - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: predicts on every input transfer and checks every output transfer.
  int idle_cycles = 0;
  always @(posedge clk) begin
    cosine_t want;
    if (rst_n) begin
      in_fired = in_valid && in_ready;
      idle_cycles = idle_cycles + 1;
      if (in_valid && in_ready) begin
        absorb_pair('{in_elem_a, in_elem_b, in_last_pair});
        idle_cycles = 0;
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (owed_cosines.size() == 0) begin
          $error("unexpected result similarity=%0d zero_norm=%0b",
                 out_similarity, out_zero_norm);
          fail_count++;
        end else begin
          want = owed_cosines.pop_front();
          if (out_similarity !== want.similarity) begin
            $error("similarity: expected %0d, got %0d", want.similarity, out_similarity);
            fail_count++;
          end
          if (out_zero_norm !== want.zero_norm) begin
            $error("zero_norm: expected %0b, got %0b", want.zero_norm, out_zero_norm);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      3: return 16'($urandom_range(7)) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // Appends one pair to the end of the pending queue.
  task automatic queue_pair(input pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  // Queues one vector of the given length with random content.
  task automatic queue_vector(input int len);
    pair_t p;
    for (int i = 0; i < len; i++) begin
      p.elem_a = pick_elem();
      p.elem_b = ($urandom_range(5) == 0) ? p.elem_a : pick_elem();
      if ($urandom_range(7) == 0) p.elem_b = -p.elem_a;
      p.last_pair = (i == len - 1);
      queue_pair(p);
    end
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_valid || owed_cosines.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int sent;
    int len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed vectors: extremes, zero norms and saturation.
    queue_pair('{16'sd0, 16'sd0, 1'b1});
    queue_pair('{16'sd100, 16'sd0, 1'b1});
    queue_pair('{16'sd0, -16'sd5, 1'b1});
    queue_pair('{16'sd32767, 16'sd32767, 1'b1});
    queue_pair('{-16'sd32768, 16'sd32767, 1'b0});
    queue_pair('{-16'sd32768, 16'sd32767, 1'b1});
    queue_pair('{-16'sd32768, -16'sd32768, 1'b1});
    queue_pair('{16'sd1, -16'sd1, 1'b0});
    queue_pair('{16'sd3, 16'sd4, 1'b1});
    queue_pair('{16'sd5, 16'sd0, 1'b0});
    queue_pair('{16'sd0, 16'sd7, 1'b1});
    sending = 1'b1;
    // Receiver holds off long enough for the unit to back up its input.
    hold_off_cycles <= 400;
    wait_drained();
    // Sender pause: restart only after every result has arrived.
    sending = 1'b0;
    repeat (DrainCycles) @(posedge clk);
    // A vector past the length cap, then one ending exactly past it.
    for (int i = 0; i < MaxElements + 6; i++)
      queue_pair('{-16'sd32768, -16'sd32768, i == MaxElements + 5});
    queue_vector(MaxElements + 1);
    sending = 1'b1;

    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      while (sent < (ph + 1) * RandomPairs / 3) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(MaxElements + 3, 1)
                                        : $urandom_range(6, 1);
        queue_vector(len);
        sent += len;
        while (pending_pairs.size() > 20) @(posedge clk);
      end
      wait_drained();
      if (ph == 0) begin
        send_idle_pct = 50;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && owed_cosines.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/csu_pkg.sv
sv/csu_ctrl.sv
sv/csu_datapath.sv
sv/cosine_similarity_unit.sv
dv/cosine_similarity_unit_tb.sv
